// ===== rtl/ibf_pkg.sv =====
// ============================================================================
// ibf_pkg
// Shared widths, coefficient table, microcode and command types for the
// sixth-order bandpass IIR filter unit.
// ============================================================================
package ibf_pkg;

    // number formats
    localparam int SAMPLE_WIDTH = 16;
    localparam int STATE_WIDTH  = 48;
    localparam int COEF_FRAC    = 26;
    localparam int STATE_FRAC   = 30;
    localparam int TAPS         = 6;

    // rescaling shifts
    localparam int IN_SHIFT  = SAMPLE_WIDTH - 1 + COEF_FRAC - STATE_FRAC;
    localparam int OUT_SHIFT = STATE_FRAC - (SAMPLE_WIDTH - 1);

    // magnitude of a saturated state value
    localparam int MAG_WIDTH = STATE_WIDTH - 1;
    localparam logic [MAG_WIDTH-1:0] STATE_LIM = '1;

    // coefficient storage and magnitude
    localparam int COEF_WIDTH     = 32;
    localparam int COEF_MAG_WIDTH = 30;

    // split of a state magnitude into two multiplier operands
    localparam int LO_WIDTH  = COEF_FRAC;
    localparam int HI_WIDTH  = MAG_WIDTH - LO_WIDTH;
    localparam int OPA_AB    = (LO_WIDTH > HI_WIDTH) ? LO_WIDTH : HI_WIDTH;
    localparam int OPA_WIDTH = (OPA_AB > SAMPLE_WIDTH) ? OPA_AB : SAMPLE_WIDTH;

    // product and rounded partial widths
    localparam int PROD_WIDTH   = OPA_WIDTH + COEF_MAG_WIDTH;
    localparam int LO_RND_WIDTH = PROD_WIDTH + 1 - COEF_FRAC;

    // sequencer
    localparam int IDX_WIDTH  = 3;
    localparam int STEP_WIDTH = 5;
    localparam logic [STEP_WIDTH-1:0] FIRST_STEP        = STEP_WIDTH'(0);
    localparam logic [STEP_WIDTH-1:0] FIRST_FILTER_STEP = STEP_WIDTH'(6);
    localparam logic [STEP_WIDTH-1:0] LAST_STEP         = STEP_WIDTH'(22);

    // coefficient selector
    typedef enum logic [3:0] {
        COEF_ZI0,
        COEF_ZI1,
        COEF_ZI2,
        COEF_ZI3,
        COEF_ZI4,
        COEF_ZI5,
        COEF_NUM0,
        COEF_NUM2,
        COEF_NUM4,
        COEF_NUM6,
        COEF_DEN1,
        COEF_DEN2,
        COEF_DEN3,
        COEF_DEN4,
        COEF_DEN5,
        COEF_DEN6
    } coef_sel_t;

    // multiplier operand selector
    typedef enum logic [1:0] {
        OPA_X,
        OPA_YLO,
        OPA_YHI
    } opa_sel_t;

    // action taken on the product in the cycle after its issue
    typedef enum logic [2:0] {
        POST_NONE,
        POST_ZI,
        POST_Y,
        POST_XT,
        POST_XZ,
        POST_LO,
        POST_LOT,
        POST_HI
    } post_op_t;

    typedef struct packed {
        opa_sel_t               opa_sel;
        coef_sel_t              coef;
        post_op_t               post;
        logic [IDX_WIDTH-1:0]   idx;
    } micro_cmd_t;

    typedef struct packed {
        logic       load;
        logic       write_out;
        micro_cmd_t op;
    } dp_cmd_t;

    localparam micro_cmd_t MICRO_NOP = '{OPA_X, COEF_ZI0, POST_NONE, IDX_WIDTH'(0)};

    // fixed coefficients, signed Q5.26
    function automatic logic signed [COEF_WIDTH-1:0] coef_value(input coef_sel_t sel);
        logic signed [COEF_WIDTH-1:0] c;
        unique case (sel)
            COEF_ZI0:  c = -32'sd1535955;
            COEF_ZI1:  c = -32'sd1535955;
            COEF_ZI2:  c =  32'sd3071911;
            COEF_ZI3:  c =  32'sd3071911;
            COEF_ZI4:  c = -32'sd1535955;
            COEF_ZI5:  c = -32'sd1535955;
            COEF_NUM0: c =  32'sd1535955;
            COEF_NUM2: c = -32'sd4607866;
            COEF_NUM4: c =  32'sd4607866;
            COEF_NUM6: c = -32'sd1535955;
            COEF_DEN1: c = -32'sd310564772;
            COEF_DEN2: c =  32'sd600660886;
            COEF_DEN3: c = -32'sd625834911;
            COEF_DEN4: c =  32'sd372780062;
            COEF_DEN5: c = -32'sd120526318;
            COEF_DEN6: c =  32'sd16376197;
            default:   c = '0;
        endcase
        return c;
    endfunction

    // microcode: one multiplier issue per step
    function automatic micro_cmd_t micro_step(input logic [STEP_WIDTH-1:0] step);
        micro_cmd_t cmd;
        unique case (step)
            // initial-condition load
            5'd0:    cmd = '{OPA_X,   COEF_ZI0,  POST_ZI,   3'd0};
            5'd1:    cmd = '{OPA_X,   COEF_ZI1,  POST_ZI,   3'd1};
            5'd2:    cmd = '{OPA_X,   COEF_ZI2,  POST_ZI,   3'd2};
            5'd3:    cmd = '{OPA_X,   COEF_ZI3,  POST_ZI,   3'd3};
            5'd4:    cmd = '{OPA_X,   COEF_ZI4,  POST_ZI,   3'd4};
            5'd5:    cmd = '{OPA_X,   COEF_ZI5,  POST_ZI,   3'd5};
            // output sample
            5'd6:    cmd = '{OPA_X,   COEF_NUM0, POST_Y,    3'd0};
            5'd7:    cmd = MICRO_NOP;
            // tap 0
            5'd8:    cmd = '{OPA_YLO, COEF_DEN1, POST_LOT,  3'd1};
            5'd9:    cmd = '{OPA_YHI, COEF_DEN1, POST_HI,   3'd0};
            // tap 1
            5'd10:   cmd = '{OPA_X,   COEF_NUM2, POST_XT,   3'd2};
            5'd11:   cmd = '{OPA_YLO, COEF_DEN2, POST_LO,   3'd0};
            5'd12:   cmd = '{OPA_YHI, COEF_DEN2, POST_HI,   3'd1};
            // tap 2
            5'd13:   cmd = '{OPA_YLO, COEF_DEN3, POST_LOT,  3'd3};
            5'd14:   cmd = '{OPA_YHI, COEF_DEN3, POST_HI,   3'd2};
            // tap 3
            5'd15:   cmd = '{OPA_X,   COEF_NUM4, POST_XT,   3'd4};
            5'd16:   cmd = '{OPA_YLO, COEF_DEN4, POST_LO,   3'd0};
            5'd17:   cmd = '{OPA_YHI, COEF_DEN4, POST_HI,   3'd3};
            // tap 4
            5'd18:   cmd = '{OPA_YLO, COEF_DEN5, POST_LOT,  3'd5};
            5'd19:   cmd = '{OPA_YHI, COEF_DEN5, POST_HI,   3'd4};
            // tap 5, no upstream state
            5'd20:   cmd = '{OPA_X,   COEF_NUM6, POST_XZ,   3'd0};
            5'd21:   cmd = '{OPA_YLO, COEF_DEN6, POST_LO,   3'd0};
            5'd22:   cmd = '{OPA_YHI, COEF_DEN6, POST_HI,   3'd5};
            default: cmd = MICRO_NOP;
        endcase
        return cmd;
    endfunction

endpackage

// ===== rtl/ibf_in_if.sv =====
// ============================================================================
// ibf_in_if
// Input sample channel: valid/ready handshake with sample and record flag.
// ============================================================================
interface ibf_in_if;

    logic                                     valid;
    logic                                     ready;
    logic signed [ibf_pkg::SAMPLE_WIDTH-1:0]  sample;
    logic                                     start_of_record;

    modport source (output valid, output sample, output start_of_record, input ready);
    modport sink   (input valid, input sample, input start_of_record, output ready);

endinterface

// ===== rtl/ibf_out_if.sv =====
// ============================================================================
// ibf_out_if
// Output sample channel: valid/ready handshake with the filtered sample.
// ============================================================================
interface ibf_out_if;

    logic                                     valid;
    logic                                     ready;
    logic signed [ibf_pkg::SAMPLE_WIDTH-1:0]  filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);

endinterface

// ===== rtl/ibf_datapath.sv =====
// ============================================================================
// ibf_datapath
// Shared magnitude multiplier, rounding and saturation, delay line and
// output register of the bandpass filter.
// ============================================================================
module ibf_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  ibf_pkg::dp_cmd_t                        cmd,
    input  logic signed [ibf_pkg::SAMPLE_WIDTH-1:0] sample,
    output logic signed [ibf_pkg::SAMPLE_WIDTH-1:0] filtered
);

    import ibf_pkg::*;

    localparam logic [PROD_WIDTH:0] X_HALF = (PROD_WIDTH + 1)'(1) << (IN_SHIFT - 1);
    localparam logic [PROD_WIDTH:0] Y_HALF = (PROD_WIDTH + 1)'(1) << (COEF_FRAC - 1);
    localparam logic [MAG_WIDTH:0]  OUT_HALF = (MAG_WIDTH + 1)'(1) << (OUT_SHIFT - 1);
    localparam logic [MAG_WIDTH:0]  OUT_MAX =
        (MAG_WIDTH + 1)'((SAMPLE_WIDTH + 1)'(1) << (SAMPLE_WIDTH - 1)) - (MAG_WIDTH + 1)'(1);
    localparam logic signed [STATE_WIDTH:0] SUM_LIM  = signed'({2'b00, STATE_LIM});
    localparam logic signed [STATE_WIDTH:0] SUM_NLIM = -SUM_LIM;
    localparam logic [SAMPLE_WIDTH-1:0] OUT_POS = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] OUT_NEG = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

    // clamp an unsigned magnitude to the state limit
    function automatic logic [MAG_WIDTH-1:0] clamp_mag(input logic [PROD_WIDTH:0] m);
        logic [MAG_WIDTH-1:0] r;
        if (m > (PROD_WIDTH + 1)'(STATE_LIM))
            r = STATE_LIM;
        else
            r = m[MAG_WIDTH-1:0];
        return r;
    endfunction

    // attach a sign to a magnitude
    function automatic logic signed [STATE_WIDTH-1:0] with_sign(
        input logic [MAG_WIDTH-1:0] mag,
        input logic                 neg
    );
        logic signed [STATE_WIDTH-1:0] v;
        v = signed'({1'b0, mag});
        return neg ? -v : v;
    endfunction

    // symmetric saturating add
    function automatic logic signed [STATE_WIDTH-1:0] sat_add(
        input logic signed [STATE_WIDTH-1:0] a,
        input logic signed [STATE_WIDTH-1:0] b
    );
        logic signed [STATE_WIDTH:0]   sum;
        logic signed [STATE_WIDTH-1:0] r;
        sum = (STATE_WIDTH + 1)'(a) + (STATE_WIDTH + 1)'(b);
        if (sum > SUM_LIM)
            r = signed'({1'b0, STATE_LIM});
        else if (sum < SUM_NLIM)
            r = -signed'({1'b0, STATE_LIM});
        else
            r = sum[STATE_WIDTH-1:0];
        return r;
    endfunction

    logic [SAMPLE_WIDTH-1:0]              x_mag_reg;
    logic                                 x_neg_reg;
    logic [MAG_WIDTH-1:0]                 y_mag_reg;
    logic                                 y_neg_reg;
    logic [PROD_WIDTH-1:0]                prod_reg;
    logic                                 neg_reg;
    post_op_t                             post_reg;
    logic [IDX_WIDTH-1:0]                 idx_reg;
    logic [LO_RND_WIDTH-1:0]              lo_reg;
    logic signed [STATE_WIDTH-1:0]        t_reg;
    logic signed [STATE_WIDTH-1:0]        state_reg [TAPS];
    logic signed [SAMPLE_WIDTH-1:0]       filtered_reg;

    logic [SAMPLE_WIDTH-1:0]              x_mag_next;
    logic [OPA_WIDTH-1:0]                 opa;
    logic                                 opa_neg;
    logic signed [COEF_WIDTH-1:0]         coef;
    logic [COEF_WIDTH-1:0]                coef_abs;
    logic [COEF_MAG_WIDTH-1:0]            coef_mag;
    logic [PROD_WIDTH:0]                  rx_sum;
    logic signed [STATE_WIDTH-1:0]        rx_term;
    logic [LO_RND_WIDTH-1:0]              lo_rnd;
    logic [PROD_WIDTH:0]                  hi_sum;
    logic signed [STATE_WIDTH-1:0]        fb_term;
    logic signed [STATE_WIDTH-1:0]        s_rd;
    logic signed [STATE_WIDTH-1:0]        y_full;
    logic [STATE_WIDTH-1:0]               y_abs;
    logic [MAG_WIDTH:0]                   out_rnd;
    logic [SAMPLE_WIDTH-1:0]              out_mag;
    logic signed [SAMPLE_WIDTH-1:0]       filtered_next;

    // input sample as sign and magnitude
    assign x_mag_next = sample[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH'(0) - unsigned'(sample))
                                               : unsigned'(sample);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_mag_reg <= x_mag_next;
            x_neg_reg <= sample[SAMPLE_WIDTH-1];
        end
    end

    // multiplier operand selection
    always_comb
    begin
        case (cmd.op.opa_sel)
            OPA_X:   opa = OPA_WIDTH'(x_mag_reg);
            OPA_YLO: opa = OPA_WIDTH'(y_mag_reg[LO_WIDTH-1:0]);
            OPA_YHI: opa = OPA_WIDTH'(y_mag_reg[MAG_WIDTH-1:LO_WIDTH]);
            default: opa = '0;
        endcase
        coef     = coef_value(cmd.op.coef);
        coef_abs = coef[COEF_WIDTH-1] ? (COEF_WIDTH'(0) - unsigned'(coef)) : unsigned'(coef);
        coef_mag = coef_abs[COEF_MAG_WIDTH-1:0];
        opa_neg  = ((cmd.op.opa_sel == OPA_X) ? x_neg_reg : y_neg_reg) ^ coef[COEF_WIDTH-1];
    end

    // shared multiplier stage
    always_ff @(posedge clk)
    begin
        prod_reg <= opa * coef_mag;
        neg_reg  <= opa_neg;
        idx_reg  <= cmd.op.idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            post_reg <= POST_NONE;
        else
            post_reg <= cmd.op.post;
    end

    // rounding and saturation of the registered product
    always_comb
    begin
        rx_sum  = {1'b0, prod_reg} + X_HALF;
        rx_term = with_sign(clamp_mag(rx_sum >> IN_SHIFT), neg_reg);
        lo_rnd  = LO_RND_WIDTH'(({1'b0, prod_reg} + Y_HALF) >> COEF_FRAC);
        hi_sum  = {1'b0, prod_reg} + (PROD_WIDTH + 1)'(lo_reg);
        fb_term = with_sign(clamp_mag(hi_sum), ~neg_reg);
        s_rd    = state_reg[idx_reg];
        y_full  = sat_add(rx_term, state_reg[0]);
        y_abs   = y_full[STATE_WIDTH-1] ? (STATE_WIDTH'(0) - unsigned'(y_full))
                                        : unsigned'(y_full);
    end

    // delay line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
                state_reg[i] <= '0;
        end
        else
        begin
            case (post_reg)
                POST_ZI: state_reg[idx_reg] <= rx_term;
                POST_HI: state_reg[idx_reg] <= sat_add(t_reg, fb_term);
                default: ;
            endcase
        end
    end

    // output sample and partial terms
    always_ff @(posedge clk)
    begin
        case (post_reg)
            POST_Y:
            begin
                y_mag_reg <= y_abs[MAG_WIDTH-1:0];
                y_neg_reg <= y_full[STATE_WIDTH-1];
            end
            POST_XT:  t_reg <= sat_add(rx_term, s_rd);
            POST_XZ:  t_reg <= rx_term;
            POST_LO:  lo_reg <= lo_rnd;
            POST_LOT:
            begin
                lo_reg <= lo_rnd;
                t_reg  <= s_rd;
            end
            default: ;
        endcase
    end

    // output rounding and clamp
    always_comb
    begin
        out_rnd = ({1'b0, y_mag_reg} + OUT_HALF) >> OUT_SHIFT;
        out_mag = out_rnd[SAMPLE_WIDTH-1:0];
        if (out_rnd > OUT_MAX)
            filtered_next = y_neg_reg ? signed'(OUT_NEG) : signed'(OUT_POS);
        else
            filtered_next = y_neg_reg ? signed'(SAMPLE_WIDTH'(0) - out_mag) : signed'(out_mag);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_out)
            filtered_reg <= filtered_next;
    end

    assign filtered = filtered_reg;

endmodule

// ===== rtl/ibf_controller.sv =====
// ============================================================================
// ibf_controller
// Sequencer of the bandpass filter: handshakes, microcode step counter and
// output valid flag.
// ============================================================================
module ibf_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_start,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output ibf_pkg::dp_cmd_t  cmd
);

    import ibf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [STEP_WIDTH-1:0]   step_reg;
    logic [STEP_WIDTH-1:0]   step_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;

    // next state and datapath commands
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        cmd.load      = 1'b0;
        cmd.write_out = 1'b0;
        cmd.op        = MICRO_NOP;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = in_start ? FIRST_STEP : FIRST_FILTER_STEP;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.op = micro_step(step_reg);
                if (step_reg == LAST_STEP)
                    state_next = ST_DONE;
                else
                    step_next = step_reg + STEP_WIDTH'(1);
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.write_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output register occupancy
    always_comb
    begin
        if (cmd.write_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/iir_bandpass_filter_unit.sv =====
// ============================================================================
// iir_bandpass_filter_unit
// Sixth-order bandpass IIR filter, transposed direct form II, fixed point.
// ============================================================================
// One Q1.15 sample in, one saturated Q1.15 sample out per transfer. A sample
// with start_of_record set first reloads the six delay registers with the
// fixed initial-condition vector times that sample (six extra reload products).
// All products go through one shared 26x30 magnitude multiplier, one partial
// product per cycle. The result waits in an output register, and the next
// sample is taken while it does; a result not yet taken holds back only the
// following one.
// ============================================================================
module iir_bandpass_filter_unit (
    input  logic         clk,
    input  logic         rst_n,
    ibf_in_if.sink       x_stream,
    ibf_out_if.source    y_stream
);

    import ibf_pkg::*;

    dp_cmd_t  cmd;
    logic     in_ready;
    logic     out_valid;

    // sequencer
    ibf_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (x_stream.valid),
        .in_start  (x_stream.start_of_record),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (y_stream.ready),
        .cmd       (cmd)
    );

    // arithmetic and delay line
    ibf_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sample   (x_stream.sample),
        .filtered (y_stream.filtered)
    );

    assign x_stream.ready = in_ready;
    assign y_stream.valid = out_valid;

endmodule
